[hdl/tplr_pkg.sv]
// ----------------------------------------------------------------------------
// Thick-pen line rasteriser package
// Shared widths, payload types and the command and status groups that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package tplr_pkg;

  // Field widths of the segment, stamp and pen width channels.
  localparam int COORD_W      = 11;
  localparam int POS_W        = 12;
  localparam int COLOR_W      = 32;
  localparam int PEN_W        = 6;

  // Default longest major extent that is still drawn.
  localparam int MAX_SPAN_DEF = 63;

  // Pen width after reset.
  localparam logic [PEN_W-1:0] PEN_RESET = PEN_W'(1);

  typedef logic        [COORD_W-1:0] coord_t;
  typedef logic signed [POS_W-1:0]   pos_t;
  typedef logic        [COLOR_W-1:0] color_t;
  typedef logic        [PEN_W-1:0]   pen_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // take the segment request from the input channel
    logic setup;    // work out extents, direction and start positions
    logic emit;     // write the current stamp to the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;  // output register is empty or being taken now
    logic last;       // the current stamp ends the segment
  } dp_stat_t;

endpackage

[hdl/tplr_if.sv]
// ----------------------------------------------------------------------------
// Thick-pen line rasteriser channels
// Valid/ready channels for segment requests, stamp results and the pen
// width register write.
// ----------------------------------------------------------------------------
interface tplr_seg_if;
  import tplr_pkg::*;

  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;
  color_t pen_color;

  modport source (output valid, start_x, start_y, end_x, end_y, pen_color,
                  input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, pen_color,
                  output ready);
endinterface

interface tplr_stamp_if;
  import tplr_pkg::*;

  logic   valid;
  logic   ready;
  pos_t   stamp_x;
  pos_t   stamp_y;
  color_t stamp_color;
  logic   last_stamp;
  logic   too_long;

  modport source (output valid, stamp_x, stamp_y, stamp_color, last_stamp, too_long,
                  input ready);
  modport sink   (input valid, stamp_x, stamp_y, stamp_color, last_stamp, too_long,
                  output ready);
endinterface

interface tplr_cfg_if;
  import tplr_pkg::*;

  logic valid;
  logic ready;
  pen_t pen_width;

  modport source (output valid, pen_width, input ready);
  modport sink   (input valid, pen_width, output ready);
endinterface

[hdl/thick_pen_line_rasterizer_core.sv]
// ----------------------------------------------------------------------------
// Thick-pen line rasteriser core
// Turns a line segment into a run of square pen stamps along its major axis.
// ----------------------------------------------------------------------------
// One segment request is taken at a time. After it is accepted the block
// goes through a set-up state and then writes one stamp per cycle into its
// output register, one for each pixel of the major axis (major extent plus
// one, at most MAX_SPAN plus one), stalling only while the output register
// is still full. A point or an overlong segment gives a single result. A
// single stepping unit serves all segments, so the next request is taken
// only once the last stamp of the current segment has been written. The
// pen width register may be written at any time the block is idle and is
// always ready.
module thick_pen_line_rasterizer_core #(
  parameter int MAX_SPAN = tplr_pkg::MAX_SPAN_DEF
) (
  input logic          clk,
  input logic          rst_n,
  tplr_seg_if.sink     in_ch,
  tplr_stamp_if.source out_ch,
  tplr_cfg_if.sink     cfg_ch
);
  import tplr_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The pen width register takes a write in every cycle.
  assign cfg_ch.ready = 1'b1;

  // Sequencer.
  tplr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // Stepping datapath and output register.
  tplr_dp #(
    .MAX_SPAN (MAX_SPAN)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .start_x       (in_ch.start_x),
    .start_y       (in_ch.start_y),
    .end_x         (in_ch.end_x),
    .end_y         (in_ch.end_y),
    .pen_color     (in_ch.pen_color),
    .cfg_we        (cfg_ch.valid),
    .cfg_pen_width (cfg_ch.pen_width),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .stamp_x       (out_ch.stamp_x),
    .stamp_y       (out_ch.stamp_y),
    .stamp_color   (out_ch.stamp_color),
    .last_stamp    (out_ch.last_stamp),
    .too_long      (out_ch.too_long)
  );

`ifndef ASSERT_OFF
  // Once a segment is taken, the next cycle is set-up and takes no request.
  a_no_back_to_back : assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("segment request accepted during set-up");

  // An overlong segment gives exactly one, final, result.
  a_err_is_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.too_long) |-> out_ch.last_stamp)
    else $error("overlong segment result not marked last");

  // An overlong segment result carries zero position and colour.
  a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.too_long) |->
      (out_ch.stamp_x == '0 && out_ch.stamp_y == '0 && out_ch.stamp_color == '0))
    else $error("overlong segment result has non-zero fields");
`endif

endmodule

[hdl/tplr_ctrl.sv]
// ----------------------------------------------------------------------------
// Thick-pen line rasteriser controller
// Sequences one segment at a time: capture, set-up, then one stamp per
// cycle while the output register has room.
// ----------------------------------------------------------------------------
module tplr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output tplr_pkg::dp_cmd_t  cmd,
  input  tplr_pkg::dp_stat_t stat
);
  import tplr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SETUP = 3'b010,
    S_RUN   = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // A new segment is only taken when no segment is being drawn.
  assign in_ready    = (state_r == S_IDLE);
  assign cmd.capture = in_ready && in_valid;
  assign cmd.setup   = (state_r == S_SETUP);
  assign cmd.emit    = (state_r == S_RUN) && stat.slot_free;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.capture) begin
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        state_nxt = S_RUN;
      end
      S_RUN: begin
        if (cmd.emit && stat.last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hdl/tplr_dp.sv]
// ----------------------------------------------------------------------------
// Thick-pen line rasteriser datapath
// Holds the segment, the pen width and the stepping state, and walks the
// major axis with an error accumulator for the minor axis.
// ----------------------------------------------------------------------------
module tplr_dp #(
  parameter int MAX_SPAN = tplr_pkg::MAX_SPAN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tplr_pkg::dp_cmd_t  cmd,
  output tplr_pkg::dp_stat_t stat,
  // segment request payload
  input  tplr_pkg::coord_t   start_x,
  input  tplr_pkg::coord_t   start_y,
  input  tplr_pkg::coord_t   end_x,
  input  tplr_pkg::coord_t   end_y,
  input  tplr_pkg::color_t   pen_color,
  // pen width register write
  input  logic               cfg_we,
  input  tplr_pkg::pen_t     cfg_pen_width,
  // stamp result
  output logic               out_valid,
  input  logic               out_ready,
  output tplr_pkg::pos_t     stamp_x,
  output tplr_pkg::pos_t     stamp_y,
  output tplr_pkg::color_t   stamp_color,
  output logic               last_stamp,
  output logic               too_long
);
  import tplr_pkg::*;

  localparam int CNT_W = $clog2(MAX_SPAN + 1);
  localparam int ACC_W = CNT_W + 1;

  // Captured segment and configuration.
  coord_t sx_r, sy_r, ex_r, ey_r;
  color_t color_r;
  pen_t   pen_width_r;

  // Stepping state.
  logic             x_major_r;
  logic             up_r;
  logic             point_r;
  logic             err_r;
  coord_t           maj_pos_r;
  coord_t           min_pos_r;
  logic [CNT_W-1:0] maj_ext_r;
  logic [CNT_W-1:0] min_ext_r;
  logic [CNT_W-1:0] cnt_r;
  logic [ACC_W-1:0] acc_r;

  // Output register.
  logic   out_valid_r;
  pos_t   stamp_x_r, stamp_y_r;
  color_t stamp_color_r;
  logic   last_stamp_r, too_long_r;

  // Set-up arithmetic.
  coord_t dx, dy, x_lo, x_hi, y_lo, y_hi, maj_ext, min_ext;
  logic   x_major, same_dir, is_point, is_long;

  // Stamp arithmetic.
  pos_t             maj_out, min_out, half, pt_x, pt_y;
  logic [ACC_W-1:0] acc_sum;
  logic             minor_step;
  logic             last_now;

  // Extents, axis choice and direction of the captured segment.
  always_comb begin
    x_lo     = (sx_r < ex_r) ? sx_r : ex_r;
    x_hi     = (sx_r < ex_r) ? ex_r : sx_r;
    y_lo     = (sy_r < ey_r) ? sy_r : ey_r;
    y_hi     = (sy_r < ey_r) ? ey_r : sy_r;
    dx       = x_hi - x_lo;
    dy       = y_hi - y_lo;
    x_major  = (dx > dy);
    maj_ext  = x_major ? dx : dy;
    min_ext  = x_major ? dy : dx;
    same_dir = ((sx_r < ex_r) == (sy_r < ey_r));
    is_point = (dx == '0) && (dy == '0);
    is_long  = (maj_ext > COORD_W'(MAX_SPAN));
  end

  // Current stamp position and the minor-axis accumulator step.
  always_comb begin
    maj_out    = pos_t'({1'b0, maj_pos_r}) - pos_t'(1);
    min_out    = pos_t'({1'b0, min_pos_r}) - pos_t'(1);
    half       = pos_t'(pen_width_r[PEN_W-1:1]);
    pt_x       = pos_t'({1'b0, sx_r}) - half;
    pt_y       = pos_t'({1'b0, sy_r}) - half;
    acc_sum    = acc_r + ACC_W'(min_ext_r);
    minor_step = (acc_sum >= ACC_W'(maj_ext_r));
    last_now   = err_r || point_r || (cnt_r == '0);
  end

  assign stat.slot_free = !out_valid_r || out_ready;
  assign stat.last      = last_now;

  // Pen width register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_width_r <= PEN_RESET;
    end else if (cfg_we) begin
      pen_width_r <= cfg_pen_width;
    end
  end

  // Segment capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sx_r    <= start_x;
      sy_r    <= start_y;
      ex_r    <= end_x;
      ey_r    <= end_y;
      color_r <= pen_color;
    end
  end

  // Stepping state: loaded at set-up, advanced on every stamp.
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      x_major_r <= x_major;
      up_r      <= same_dir;
      point_r   <= is_point;
      err_r     <= is_long && !is_point;
      maj_pos_r <= same_dir ? (x_major ? x_lo : y_lo) : (x_major ? x_hi : y_hi);
      min_pos_r <= x_major ? y_lo : x_lo;
      maj_ext_r <= maj_ext[CNT_W-1:0];
      min_ext_r <= min_ext[CNT_W-1:0];
      cnt_r     <= maj_ext[CNT_W-1:0];
      acc_r     <= '0;
    end else if (cmd.emit) begin
      maj_pos_r <= up_r ? (maj_pos_r + COORD_W'(1)) : (maj_pos_r - COORD_W'(1));
      cnt_r     <= cnt_r - CNT_W'(1);
      if (minor_step) begin
        acc_r     <= acc_sum - ACC_W'(maj_ext_r);
        min_pos_r <= min_pos_r + COORD_W'(1);
      end else begin
        acc_r <= acc_sum;
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      last_stamp_r <= last_now;
      too_long_r   <= err_r;
      if (err_r) begin
        stamp_x_r     <= '0;
        stamp_y_r     <= '0;
        stamp_color_r <= '0;
      end else if (point_r) begin
        stamp_x_r     <= pt_x;
        stamp_y_r     <= pt_y;
        stamp_color_r <= color_r;
      end else begin
        stamp_x_r     <= x_major_r ? maj_out : min_out;
        stamp_y_r     <= x_major_r ? min_out : maj_out;
        stamp_color_r <= color_r;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign stamp_x     = stamp_x_r;
  assign stamp_y     = stamp_y_r;
  assign stamp_color = stamp_color_r;
  assign last_stamp  = last_stamp_r;
  assign too_long    = too_long_r;

endmodule

[tb/thick_pen_line_rasterizer_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Thick-pen line rasteriser core testbench
// Drives segment requests and pen width writes into the core. Every stamp it
// gets back is checked against stamps worked out here, under random idling
// on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module thick_pen_line_rasterizer_core_tb;
  import tplr_pkg::*;

  localparam int SPAN_LIMIT = MAX_SPAN_DEF;
  localparam int COORD_TOP  = (1 << COORD_W) - 1;

  // One stamp as the result channel carries it.
  typedef struct packed {
    pos_t   x;
    pos_t   y;
    color_t color;
    logic   last;
    logic   overlong;
  } stamp_t;

  logic clk;
  logic rst_n;

  tplr_seg_if   seg_bus ();
  tplr_stamp_if stamp_bus ();
  tplr_cfg_if   cfg_bus ();

  thick_pen_line_rasterizer_core #(
    .MAX_SPAN(SPAN_LIMIT)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (seg_bus),
    .out_ch(stamp_bus),
    .cfg_ch(cfg_bus)
  );

  // Stamps still owed by the core, oldest first.
  stamp_t stamp_expect_q[$];

  pen_t pen_shadow;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_cycles;
  int   fail_count;
  int   segs_sent;
  int   points_sent;
  int   overlong_sent;
  int   stamps_checked;
  int   pen_writes;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Overall limit on the run.
  initial begin
    #10000000;
    $display("thick_pen_line_rasterizer_core_tb: FAIL");
    $finish;
  end

  // Add one stamp to the end of the list of stamps still owed.
  function automatic void owe_stamp(input stamp_t s);
    stamp_expect_q = {stamp_expect_q, s};
  endfunction

  // Work out the stamps that one segment request gives and queue them.
  function automatic void predict_stamps(input coord_t sx_c, input coord_t sy_c,
                                         input coord_t ex_c, input coord_t ey_c,
                                         input color_t col);
    int     sx, sy, ex, ey;
    int     dx, dy, maj_ext, min_ext, maj_min, min_min, maj_sum;
    int     half, n, k, maj, mnr;
    bit     same_dir, x_major;
    stamp_t s;
    sx = sx_c;
    sy = sy_c;
    ex = ex_c;
    ey = ey_c;
    dx = (sx > ex) ? sx - ex : ex - sx;
    dy = (sy > ey) ? sy - ey : ey - sy;
    same_dir = ((sx < ex) == (sy < ey));
    x_major  = (dx > dy);
    maj_ext  = x_major ? dx : dy;
    min_ext  = x_major ? dy : dx;

    // A point gives one stamp centred on it.
    if (sx == ex && sy == ey) begin
      half = int'(pen_shadow) / 2;
      s = '{pos_t'(sx - half), pos_t'(sy - half), col, 1'b1, 1'b0};
      owe_stamp(s);
      points_sent++;
      return;
    end

    // Too long to draw: a single flagged result with empty fields.
    if (maj_ext > SPAN_LIMIT) begin
      s = '{pos_t'(0), pos_t'(0), color_t'(0), 1'b1, 1'b1};
      owe_stamp(s);
      overlong_sent++;
      return;
    end

    // Step along the major axis, mirroring when the directions differ.
    maj_min = x_major ? ((sx < ex) ? sx : ex) : ((sy < ey) ? sy : ey);
    min_min = x_major ? ((sy < ey) ? sy : ey) : ((sx < ex) ? sx : ex);
    maj_sum = x_major ? sx + ex : sy + ey;
    n = maj_ext + 1;
    for (k = 0; k < n; k++) begin
      maj = same_dir ? maj_min + k - 1 : maj_sum - (maj_min + k) - 1;
      mnr = min_min + (min_ext * k) / maj_ext - 1;
      if (x_major) begin
        s = '{pos_t'(maj), pos_t'(mnr), col, (k == n - 1), 1'b0};
      end else begin
        s = '{pos_t'(mnr), pos_t'(maj), col, (k == n - 1), 1'b0};
      end
      owe_stamp(s);
    end
  endfunction

  // Move a coordinate by d, reflecting the step when it would leave the range.
  function automatic coord_t shift_coord(input coord_t c, input int d);
    int e;
    e = int'(c) + d;
    if (e > COORD_TOP || e < 0) begin
      e = int'(c) - d;
    end
    return coord_t'(e);
  endfunction

  // Result side: ready with random idling, or held low for a counted stretch.
  initial begin
    stamp_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        stamp_bus.ready = 1'b0;
        hold_cycles--;
      end else begin
        stamp_bus.ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Compare every accepted stamp with the oldest one still owed.
  always @(posedge clk) begin : check_stamps
    stamp_t got;
    stamp_t want;
    if (rst_n && stamp_bus.valid && stamp_bus.ready) begin
      got = '{stamp_bus.stamp_x, stamp_bus.stamp_y, stamp_bus.stamp_color,
              stamp_bus.last_stamp, stamp_bus.too_long};
      if (stamp_expect_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected stamp x=%0d y=%0d color=%h last=%b too_long=%b",
                 $time, got.x, got.y, got.color, got.last, got.overlong);
      end else begin
        want = stamp_expect_q.pop_front();
        stamps_checked++;
        if (got !== want) begin
          fail_count++;
          $display("%0t: stamp mismatch, expected x=%0d y=%0d color=%h last=%b too_long=%b",
                   $time, want.x, want.y, want.color, want.last, want.overlong);
          $display("%0t:                 actual x=%0d y=%0d color=%h last=%b too_long=%b",
                   $time, got.x, got.y, got.color, got.last, got.overlong);
        end
      end
    end
  end

  // Offer one segment request and wait until the core takes it.
  // Called and returns at a falling edge.
  task automatic send_segment(input coord_t sx, input coord_t sy,
                              input coord_t ex, input coord_t ey,
                              input color_t col);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      seg_bus.valid = 1'b0;
      @(negedge clk);
    end
    seg_bus.start_x   = sx;
    seg_bus.start_y   = sy;
    seg_bus.end_x     = ex;
    seg_bus.end_y     = ey;
    seg_bus.pen_color = col;
    seg_bus.valid     = 1'b1;
    do @(posedge clk); while (!seg_bus.ready);
    predict_stamps(sx, sy, ex, ey, col);
    segs_sent++;
    @(negedge clk);
    seg_bus.valid = 1'b0;
  endtask

  // Wait until every owed stamp has come, then let the core settle.
  task automatic wait_drained();
    while (stamp_expect_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // Write the pen width while the core is idle.
  task automatic write_pen_width(input pen_t w);
    wait_drained();
    cfg_bus.pen_width = w;
    cfg_bus.valid     = 1'b1;
    do @(posedge clk); while (!cfg_bus.ready);
    pen_shadow = w;
    pen_writes++;
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // Edges of the coordinate range, both axis choices, both directions and
  // the limit on the major extent, at the reset pen width.
  task automatic test_directed_segments();
    send_idle_pct = 30;
    recv_idle_pct = 30;
    send_segment(11'd0, 11'd0, 11'd0, 11'd0, 32'h0000_0000);
    send_segment(11'd2047, 11'd2047, 11'd2047, 11'd2047, 32'hFFFF_FFFF);
    send_segment(11'd0, 11'd0, 11'd5, 11'd0, 32'h1234_5678);
    send_segment(11'd10, 11'd3, 11'd4, 11'd3, 32'h8765_4321);
    send_segment(11'd7, 11'd0, 11'd7, 11'd6, 32'hA5A5_A5A5);
    send_segment(11'd7, 11'd9, 11'd7, 11'd2, 32'h5A5A_5A5A);
    send_segment(11'd0, 11'd0, 11'd4, 11'd4, 32'h0F0F_0F0F);
    send_segment(11'd0, 11'd4, 11'd4, 11'd0, 32'hF0F0_F0F0);
    send_segment(11'd2, 11'd10, 11'd12, 11'd5, 32'hDEAD_BEEF);
    send_segment(11'd9, 11'd1, 11'd3, 11'd20, 32'hCAFE_F00D);
    send_segment(11'd0, 11'd0, 11'd63, 11'd17, 32'h0000_0001);
    send_segment(11'd0, 11'd0, 11'd64, 11'd0, 32'h8000_0000);
    send_segment(11'd2047, 11'd2047, 11'd2000, 11'd1984, 32'h7FFF_FFFF);
    send_segment(11'd0, 11'd0, 11'd2047, 11'd2047, 32'hFFFF_0000);
    send_segment(11'd2047, 11'd0, 11'd0, 11'd2047, 32'h0000_FFFF);
    send_segment(11'd2047, 11'd2047, 11'd1990, 11'd2040, 32'h1357_9BDF);
    send_segment(11'd100, 11'd100, 11'd101, 11'd100, 32'h2468_ACE0);
    send_segment(11'd100, 11'd100, 11'd100, 11'd99, 32'h0102_0304);
    send_segment(11'd0, 11'd2047, 11'd1, 11'd1984, 32'h5555_AAAA);
    send_segment(11'd1024, 11'd512, 11'd1024, 11'd576, 32'hAAAA_5555);
    wait_drained();
  endtask

  // Pen widths from zero to the top of the register, seen through points.
  task automatic test_pen_width_extremes();
    pen_t widths[9];
    int   j;
    widths = '{6'd0, 6'd1, 6'd2, 6'd3, 6'd31, 6'd32, 6'd33, 6'd62, 6'd63};
    for (j = 0; j < 9; j++) begin
      write_pen_width(widths[j]);
      send_segment(11'd0, 11'd0, 11'd0, 11'd0, $urandom);
      send_segment(11'd2047, 11'd2047, 11'd2047, 11'd2047, $urandom);
      send_segment(11'd40, 11'd40, 11'd43, 11'd38, $urandom);
    end
    wait_drained();
  endtask

  // Random segments in three idling phases, mostly within the span limit.
  task automatic test_random_segments();
    int     phase, kind, span, minor, d_major, d_minor;
    coord_t sx, sy, ex, ey;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 20;
          recv_idle_pct = 70;
        end
        1: begin
          send_idle_pct = 70;
          recv_idle_pct = 20;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if ($urandom_range(0, 3) == 0) begin
        write_pen_width(pen_t'($urandom_range(0, 63)));
      end else begin
        write_pen_width(pen_t'($urandom_range(1, 32)));
      end
      repeat (66) begin
        kind = $urandom_range(0, 99);
        sx = coord_t'($urandom_range(0, COORD_TOP));
        sy = coord_t'($urandom_range(0, COORD_TOP));
        if (kind < 10) begin
          ex = sx;
          ey = sy;
        end else if (kind < 20) begin
          ex = coord_t'($urandom_range(0, COORD_TOP));
          ey = coord_t'($urandom_range(0, COORD_TOP));
        end else begin
          span  = (kind < 80) ? $urandom_range(1, 12) : $urandom_range(13, SPAN_LIMIT);
          minor = $urandom_range(0, span);
          d_major = $urandom_range(0, 1) ? span : -span;
          d_minor = $urandom_range(0, 1) ? minor : -minor;
          if ($urandom_range(0, 1)) begin
            ex = shift_coord(sx, d_major);
            ey = shift_coord(sy, d_minor);
          end else begin
            ex = shift_coord(sx, d_minor);
            ey = shift_coord(sy, d_major);
          end
        end
        send_segment(sx, sy, ex, ey, $urandom);
      end
      wait_drained();
    end
  endtask

  // Hold the result side off for a long stretch while long segments keep
  // coming, so that the core fills up and stops taking requests.
  task automatic test_output_backpressure();
    coord_t sx, sy;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles   = 400;
    repeat (5) begin
      sx = coord_t'($urandom_range(64, COORD_TOP - 64));
      sy = coord_t'($urandom_range(64, COORD_TOP - 64));
      send_segment(sx, sy, shift_coord(sx, $urandom_range(30, SPAN_LIMIT)),
                   shift_coord(sy, -$urandom_range(0, 29)), $urandom);
    end
    wait_drained();
  endtask

  // Reset, run each test in turn and report.
  initial begin
    rst_n             = 1'b0;
    seg_bus.valid     = 1'b0;
    seg_bus.start_x   = '0;
    seg_bus.start_y   = '0;
    seg_bus.end_x     = '0;
    seg_bus.end_y     = '0;
    seg_bus.pen_color = '0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.pen_width = '0;
    pen_shadow        = PEN_RESET;
    send_idle_pct     = 0;
    recv_idle_pct     = 0;
    hold_cycles       = 0;
    fail_count        = 0;
    segs_sent         = 0;
    points_sent       = 0;
    overlong_sent     = 0;
    stamps_checked    = 0;
    pen_writes        = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_segments();
    test_pen_width_extremes();
    test_random_segments();
    test_output_backpressure();
    write_pen_width(PEN_RESET);

    wait_drained();
    repeat (80) @(posedge clk);

    $display("Run covered %0d segments (%0d points, %0d overlong) and %0d stamps checked.",
             segs_sent, points_sent, overlong_sent, stamps_checked);
    $display("It used %0d pen width writes, three idling phases and one long output hold-off.",
             pen_writes);
    if (fail_count == 0) begin
      $display("thick_pen_line_rasterizer_core_tb: PASS");
    end else begin
      $display("thick_pen_line_rasterizer_core_tb: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/tplr_pkg.sv
hdl/tplr_if.sv
hdl/tplr_ctrl.sv
hdl/tplr_dp.sv
hdl/thick_pen_line_rasterizer_core.sv
tb/thick_pen_line_rasterizer_core_tb.sv
